// ----- rtl/upst_pkg.sv -----
`timescale 1ns / 1ps

package upst_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_FIND   = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic             cap;
      logic             shift;
      logic             rd_en;
      logic [IDX_W-1:0] rd_pos;
      logic [CNT_W-1:0] count;
      entry_type        cmp;
   } cell_ctrl_type;

   typedef struct packed {
      logic      match;
      entry_type rd;
   } cell_stat_type;

endpackage

// ----- rtl/upst_cell.sv -----
`timescale 1ns / 1ps

module upst_cell
   import upst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [IDX_W-1:0] cell_pos,
   input  cell_ctrl_type ctrl,
   input  entry_type     prev_entry,
   output entry_type     own_entry,
   output cell_stat_type stat
);

   entry_type     entry_ff;
   cell_stat_type stat_ff;
   cell_stat_type stat_in;
   logic          in_use;
   logic          sel;

   assign in_use = {1'b0, cell_pos} < ctrl.count;
   assign sel    = in_use && ctrl.rd_en && (cell_pos == ctrl.rd_pos);

   always_comb begin
      stat_in.match = in_use && (entry_ff == ctrl.cmp);
      stat_in.rd    = sel ? entry_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         entry_ff <= prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stat_ff <= '0;
      end else if (ctrl.cap) begin
         stat_ff <= stat_in;
      end
   end

   assign own_entry = entry_ff;
   assign stat      = stat_ff;

endmodule

// ----- rtl/unique_pair_set_table.sv -----
`timescale 1ns / 1ps

// set of (key, value) pairs in insertion order, held in a row of 64 cells.
// in the accept cycle each cell compares its pair with the request and
// latches its read data; once the output register is free, the cell flags
// are combined and the result is registered. a new pair enters cell 0 and
// older pairs move one cell along, so position i lives in cell count-1-i.
// one operation is in flight at a time; a finished result may wait in the
// output register while the next transaction is accepted, and that
// transaction then stays in evaluation until the waiting result is taken.
module unique_pair_set_table
   import upst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // func[1:0], pair_key[33:2], pair_value[97:34], entry_index[103:98]
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit[0], inserted[1], table_full[2], entry_count[9:3], read_key[41:10],
   // read_value[105:42], last_entry[106], zero fill[111:107]
   output logic [111:0] rsp_tdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       func_ff;
   entry_type        query_ff;
   logic             rd_ok_ff;
   logic             last_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [111:0]     rsp_data_ff, rsp_data_in;

   logic [1:0]       req_func;
   entry_type        req_entry;
   logic [5:0]       req_idx;
   logic             accept;
   logic             done;
   logic             rd_ok;
   logic [CNT_W-1:0] rd_pos;

   cell_ctrl_type    ctrl;
   entry_type        chain [CAPACITY+1];
   cell_stat_type    stats [CAPACITY];

   logic             any_match;
   entry_type        rd_data;
   logic             hit, ins, full;
   logic [CNT_W-1:0] count_out;

   assign req_func        = req_tdata[1:0];
   assign req_entry.key   = req_tdata[33:2];
   assign req_entry.value = req_tdata[97:34];
   assign req_idx         = req_tdata[103:98];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign done       = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_tready);

   assign rd_ok  = (req_func == FUNC_READ) && ({1'b0, req_idx} < count_ff);
   assign rd_pos = count_ff - CNT_W'(1) - CNT_W'(req_idx);

   always_comb begin
      ctrl.cap    = accept;
      ctrl.shift  = ins && done;
      ctrl.rd_en  = rd_ok;
      ctrl.rd_pos = rd_pos[IDX_W-1:0];
      ctrl.count  = count_ff;
      ctrl.cmp    = req_entry;
   end

   assign chain[0] = query_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      upst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_pos   (IDX_W'(g)),
         .ctrl       (ctrl),
         .prev_entry (chain[g]),
         .own_entry  (chain[g+1]),
         .stat       (stats[g])
      );
   end

   always_comb begin
      any_match = 1'b0;
      rd_data   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         any_match = any_match | stats[i].match;
         rd_data   = rd_data | stats[i].rd;
      end
   end

   always_comb begin
      hit  = 1'b0;
      ins  = 1'b0;
      full = 1'b0;
      unique case (func_ff)
         FUNC_INSERT: begin
            hit  = any_match;
            full = !any_match && (count_ff == CNT_W'(CAPACITY));
            ins  = !any_match && (count_ff != CNT_W'(CAPACITY));
         end
         FUNC_FIND: hit = any_match;
         FUNC_READ: hit = rd_ok_ff;
         default:   hit = 1'b0;
      endcase
   end

   assign count_out = ins ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      rsp_data_in           = '0;
      rsp_data_in[0]        = hit;
      rsp_data_in[1]        = ins;
      rsp_data_in[2]        = full;
      rsp_data_in[9:3]      = 7'(count_out);
      rsp_data_in[41:10]    = rd_data.key;
      rsp_data_in[105:42]   = rd_data.value;
      rsp_data_in[106]      = last_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EVAL;
         ST_EVAL: if (done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign count_in     = done ? count_out : count_ff;
   assign rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         query_ff <= req_entry;
         rd_ok_ff <= rd_ok;
         last_ff  <= rd_ok && ({1'b0, req_idx} + CNT_W'(1) == count_ff);
      end
      if (done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
